### hw/rtl/bmp_pkg.sv
// shared constants for the binomial coefficient mod prime block
`timescale 1ns / 1ps
package bmp_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VAL_W       = 31;
  localparam int FIELD_W     = 10;
  localparam int MUL_STEPS   = VAL_W;
  localparam int STEP_W      = $clog2(MUL_STEPS);
  localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(1000000007);
endpackage

### hw/rtl/bmp_modmul.sv
// bit-serial modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module bmp_modmul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bmp_pkg::VAL_W-1:0]  a,
  input  logic [bmp_pkg::VAL_W-1:0]  b,
  input  logic [bmp_pkg::VAL_W-1:0]  m,
  output logic                       done,
  output logic [bmp_pkg::VAL_W-1:0]  product
);
  import bmp_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  a_r;
  logic [VAL_W-1:0]  b_r;
  logic [VAL_W+1:0]  sum;
  logic [VAL_W+1:0]  m1;
  logic [VAL_W+1:0]  m2;
  logic [VAL_W-1:0]  acc_next;

  // double, add next partial product, reduce below m
  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, acc, 1'b0} + (b_r[VAL_W-1] ? {2'b00, a_r} : '0);
    if (sum >= m2) begin
      acc_next = VAL_W'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = VAL_W'(sum - m1);
    end else begin
      acc_next = VAL_W'(sum);
    end
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(MUL_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= {b_r[VAL_W-2:0], 1'b0};
    end
  end

  assign product = acc;
endmodule

### hw/rtl/binomial_mod_prime.sv
// binomial coefficient mod a configured prime, Fermat inverses on a shared multiplier
// one shared bit-serial multiplier serves every modular product;
//   a query with n >= r > 0 takes up to two 31-bit exponentiations (at most 62 products
//   each) plus two products; trivial cases skip the multiplier
// throughput: one query at a time, in_stall is high until the result is taken
// reset: modulus returns to 1000000007 and the factorial table is rebuilt;
//   a modulus write starts the same rebuild
`timescale 1ns / 1ps
module binomial_mod_prime (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bmp_pkg::FIELD_W-1:0]  set_size,
  input  logic [bmp_pkg::FIELD_W-1:0]  choose_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bmp_pkg::VAL_W-1:0]    binomial_value,
  input  logic                         cfg_we,
  input  logic [bmp_pkg::VAL_W-1:0]    cfg_wdata
);
  import bmp_pkg::*;

  typedef enum logic [3:0] {
    ST_BUILD_INIT, ST_IDLE, ST_READ, ST_LOAD, ST_POW_CHK, ST_MWAIT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    RET_BUILD, RET_POW_ACC, RET_POW_SQR, RET_FIN1, RET_FIN2
  } ret_t;

  state_t            state;
  ret_t              ret;
  logic [VAL_W-1:0]  modulus;
  logic [FIELD_W-1:0] n_r;
  logic [FIELD_W-1:0] r_r;
  logic [1:0]        ph;
  logic [ADDR_W-1:0] idx;
  logic [VAL_W-1:0]  imod;
  logic [VAL_W-1:0]  imod_next;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  x;
  logic [VAL_W-1:0]  e;
  logic [VAL_W-1:0]  inv_r;
  logic [VAL_W-1:0]  inv_nr;
  logic [VAL_W-1:0]  t1;
  logic [VAL_W-1:0]  res;
  logic              mm_start;
  logic [VAL_W-1:0]  mm_a;
  logic [VAL_W-1:0]  mm_b;
  logic              mm_done;
  logic [VAL_W-1:0]  mm_p;

  logic [VAL_W-1:0]  mem [TABLE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [VAL_W-1:0]  mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  logic [VAL_W-1:0]  mem_rd;

  bmp_modmul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .m       (modulus),
    .done    (mm_done),
    .product (mm_p)
  );

  // table write and read ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = mm_p;
    if (state == ST_BUILD_INIT && modulus >= VAL_W'(2)) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = VAL_W'(1);
    end else if (state == ST_MWAIT && mm_done && ret == RET_BUILD) begin
      mem_we = 1'b1;
    end
    unique case (ph)
      2'd0:    mem_ra = ADDR_W'(r_r);
      2'd1:    mem_ra = ADDR_W'(n_r - r_r);
      default: mem_ra = ADDR_W'(n_r);
    endcase
  end

  // factorial table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  // next value of the sweep's running index mod m
  assign imod_next = (imod + VAL_W'(1) == modulus) ? '0 : imod + VAL_W'(1);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_BUILD_INIT;
      modulus  <= MOD_RESET;
      mm_start <= 1'b0;
      ret      <= RET_BUILD;
      ph       <= '0;
    end else begin
      mm_start <= 1'b0;
      if (cfg_we) begin
        modulus <= cfg_wdata;
        state   <= ST_BUILD_INIT;
      end else begin
        unique case (state)
          ST_BUILD_INIT: begin
            if (modulus < VAL_W'(2)) begin
              state <= ST_IDLE;
            end else begin
              idx      <= ADDR_W'(1);
              imod     <= VAL_W'(1);
              mm_a     <= VAL_W'(1);
              mm_b     <= VAL_W'(1);
              mm_start <= 1'b1;
              ret      <= RET_BUILD;
              state    <= ST_MWAIT;
            end
          end
          ST_IDLE: begin
            if (in_valid) begin
              n_r <= set_size;
              r_r <= choose_count;
              ph  <= '0;
              if (modulus < VAL_W'(2) || set_size < choose_count) begin
                res   <= '0;
                state <= ST_OUT;
              end else if (choose_count == '0) begin
                res   <= VAL_W'(1);
                state <= ST_OUT;
              end else if (ADDR_W'(set_size) != set_size[ADDR_W-1:0] ||
                           {1'b0, set_size} >= (FIELD_W+1)'(TABLE_DEPTH)) begin
                res   <= '0;
                state <= ST_OUT;
              end else begin
                state <= ST_READ;
              end
            end
          end
          ST_READ: begin
            state <= ST_LOAD;
          end
          ST_LOAD: begin
            if (ph == 2'd2) begin
              mm_a     <= mem_rd;
              mm_b     <= inv_r;
              mm_start <= 1'b1;
              ret      <= RET_FIN1;
              state    <= ST_MWAIT;
            end else begin
              acc   <= VAL_W'(1);
              x     <= mem_rd;
              e     <= modulus - VAL_W'(2);
              state <= ST_POW_CHK;
            end
          end
          ST_POW_CHK: begin
            if (e == '0) begin
              if (ph == 2'd0) begin
                inv_r <= acc;
              end else begin
                inv_nr <= acc;
              end
              ph    <= ph + 2'd1;
              state <= ST_READ;
            end else if (e[0]) begin
              mm_a     <= acc;
              mm_b     <= x;
              mm_start <= 1'b1;
              ret      <= RET_POW_ACC;
              state    <= ST_MWAIT;
            end else begin
              mm_a     <= x;
              mm_b     <= x;
              mm_start <= 1'b1;
              ret      <= RET_POW_SQR;
              state    <= ST_MWAIT;
            end
          end
          ST_MWAIT: begin
            if (mm_done) begin
              unique case (ret)
                RET_BUILD: begin
                  if (idx == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state <= ST_IDLE;
                  end else begin
                    idx      <= idx + 1'b1;
                    imod     <= imod_next;
                    mm_a     <= mm_p;
                    mm_b     <= imod_next;
                    mm_start <= 1'b1;
                  end
                end
                RET_POW_ACC: begin
                  acc      <= mm_p;
                  mm_a     <= x;
                  mm_b     <= x;
                  mm_start <= 1'b1;
                  ret      <= RET_POW_SQR;
                end
                RET_POW_SQR: begin
                  x     <= mm_p;
                  e     <= e >> 1;
                  state <= ST_POW_CHK;
                end
                RET_FIN1: begin
                  t1       <= mm_p;
                  mm_a     <= mm_p;
                  mm_b     <= inv_nr;
                  mm_start <= 1'b1;
                  ret      <= RET_FIN2;
                end
                RET_FIN2: begin
                  res   <= mm_p;
                  state <= ST_OUT;
                end
                default: state <= ST_IDLE;
              endcase
            end
          end
          ST_OUT: begin
            if (!out_stall) begin
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  assign in_stall       = (state != ST_IDLE);
  assign out_valid      = (state == ST_OUT);
  assign binomial_value = res;

  // result never leaves the block while a new query can be taken
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("result shown while input open");

  // an accepted query closes the input on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after transaction");

  // every result is reduced below a real modulus
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && modulus >= VAL_W'(2)) |-> binomial_value < modulus)
    else $error("result not reduced");

  // the final product is taken from the first final product
  assert property (@(posedge clk) disable iff (rst)
    (mm_start && ret == RET_FIN2) |-> mm_a == t1)
    else $error("final product operand mismatch");
endmodule

### tb/binomial_mod_prime_test.sv
// testbench for binomial_mod_prime: queued driver, checking monitor and predictor
`timescale 1ns / 1ps
module binomial_mod_prime_test;
  import bmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 250000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NUM_SETTINGS   = 10;
  localparam int RANDOM_PER_SET = 132;

  typedef struct packed {
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] r;
  } query_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] set_size = '0;
  logic [FIELD_W-1:0] choose_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VAL_W-1:0]   binomial_value;
  logic               cfg_we = 1'b0;
  logic [VAL_W-1:0]   cfg_wdata = '0;

  query_t             pending_queries[$];
  logic [VAL_W-1:0]   expected_values[$];
  logic [VAL_W-1:0]   modulus_now;
  logic [VAL_W-1:0]   factorials[TABLE_DEPTH];
  logic               query_taken = 1'b0;
  int                 send_gap = 0;
  int                 recv_gap = 0;
  bit                 no_idle = 1'b0;
  int                 errors = 0;
  int                 quiet_cycles = 0;

  binomial_mod_prime uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .set_size(set_size), .choose_count(choose_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .binomial_value(binomial_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [VAL_W-1:0] mul_mod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                               logic [VAL_W-1:0] m);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return VAL_W'(prod % 64'(m));
  endfunction

  function automatic logic [VAL_W-1:0] pow_mod(logic [VAL_W-1:0] base, logic [VAL_W-1:0] ex,
                                               logic [VAL_W-1:0] m);
    logic [VAL_W-1:0] acc;
    logic [VAL_W-1:0] x;
    acc = VAL_W'(1) % m;
    x = base % m;
    while (ex != '0) begin
      if (ex[0]) acc = mul_mod(acc, x, m);
      ex = ex >> 1;
      x = mul_mod(x, x, m);
    end
    return acc;
  endfunction

  // factorial table as the block rebuilds it
  function automatic void load_modulus(logic [VAL_W-1:0] m);
    modulus_now = m;
    if (m < VAL_W'(2)) begin
      for (int i = 0; i < TABLE_DEPTH; i++) factorials[i] = '0;
    end else begin
      factorials[0] = VAL_W'(1);
      for (int i = 1; i < TABLE_DEPTH; i++)
        factorials[i] = mul_mod(factorials[i-1], VAL_W'(i) % m, m);
    end
  endfunction

  function automatic logic [VAL_W-1:0] binomial_mod(query_t q);
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] inv_r;
    logic [VAL_W-1:0] inv_nr;
    m = modulus_now;
    if (m < VAL_W'(2) || q.n < q.r) return '0;
    if (q.r == '0) return VAL_W'(1);
    if (int'(q.n) >= TABLE_DEPTH) return '0;
    inv_r  = pow_mod(factorials[q.r], m - VAL_W'(2), m);
    inv_nr = pow_mod(factorials[q.n - q.r], m - VAL_W'(2), m);
    return mul_mod(mul_mod(factorials[q.n], inv_r, m), inv_nr, m);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic void add_query(int n, int r);
    query_t q;
    q.n = FIELD_W'(n);
    q.r = FIELD_W'(r);
    pending_queries.push_back(q);
  endfunction

  // mostly n >= r, some trivial choices, some fully random pairs
  function automatic void add_random_queries(int count);
    int n;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      n = $urandom_range(0, 1023);
      if (roll < 75) add_query(n, $urandom_range(0, n));
      else if (roll < 82) add_query(n, 0);
      else if (roll < 88) add_query(n, n);
      else add_query(n, $urandom_range(0, 1023));
    end
  endfunction

  // input driver, one transaction at a time
  always @(negedge clk) begin
    if ($urandom_range(0, 59) == 0) no_idle <= ~no_idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || query_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_queries.size() != 0) begin
        query_t q;
        q = pending_queries.pop_front();
        set_size     <= q.n;
        choose_count <= q.r;
        in_valid     <= 1'b1;
        send_gap     <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      recv_gap <= pick_gap();
    end
  end

  // monitor: predict on accepted queries, check accepted results
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    query_t q;
    query_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      q.n = set_size;
      q.r = choose_count;
      expected_values.push_back(binomial_mod(q));
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        errors++;
        $display("%0t: unexpected result binomial_value=%0d", $time, binomial_value);
      end else begin
        want = expected_values.pop_front();
        if (binomial_value !== want) begin
          errors++;
          $display("%0t: binomial_value expected %0d actual %0d", $time, want, binomial_value);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_queries.size() != 0 || in_valid || expected_values.size() != 0)
      @(negedge clk);
  endtask

  // modulus settings: reset value, extremes, below-two, composite, small primes
  logic [VAL_W-1:0] moduli[NUM_SETTINGS] = '{
    VAL_W'(1000000007), VAL_W'(2147483647), VAL_W'(2), VAL_W'(7), VAL_W'(0),
    VAL_W'(1), VAL_W'(1000000), VAL_W'(65537), VAL_W'(3), VAL_W'(998244353)
  };

  initial begin
    load_modulus(MOD_RESET);
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    // directed corners under the reset modulus
    add_query(0, 0);       add_query(1023, 1023); add_query(1023, 0);
    add_query(0, 1023);    add_query(1023, 1);    add_query(1023, 1022);
    add_query(1023, 512);  add_query(512, 1023);  add_query(1, 1);
    add_query(1, 0);       add_query(10, 3);      add_query(682, 341);
    add_query(341, 682);   add_query(1000, 999);  add_query(999, 1000);
    add_query(1022, 511);  add_query(2, 1);       add_query(5, 5);
    add_random_queries(RANDOM_PER_SET);
    for (int s = 1; s < NUM_SETTINGS; s++) begin
      wait_idle();
      repeat (5) @(negedge clk);
      cfg_wdata <= moduli[s];
      cfg_we    <= 1'b1;
      load_modulus(moduli[s]);
      @(negedge clk);
      cfg_we    <= 1'b0;
      add_query(1023, 1023); add_query(1023, 511); add_query(0, 1);
      add_random_queries(RANDOM_PER_SET);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_values.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
